// File: hw/rtl/iir_df1_pkg.sv
// Shared types and constants for the third-order direct form I IIR filter.
// Used by the channel interfaces, the register bank, the MAC unit and the top level.
`timescale 1ns / 1ps

package iir_df1_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int STAMP_W   = 32;
  localparam int COEF_W    = 18;
  localparam int FRAC_BITS = 14;

  // Filter order; the register map always holds b0..b3 and a1..a3.
  localparam int ORDER       = 3;
  localparam int NUM_REGS    = 7;
  localparam int A1_REG_IDX  = 4;

  localparam int NUM_TAPS = 2 * ORDER + 1;
  localparam int TAP_W    = $clog2(NUM_TAPS);
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int SH_W     = ACC_W - FRAC_BITS;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [SH_W-1:0]  SAT_MAX    = SH_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SH_W-1:0]  SAT_MIN    = SH_W'(-(2 ** (SAMPLE_W - 1)));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [STAMP_W-1:0]         stamp_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef coef_t [NUM_REGS-1:0]       coef_bank_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic sub;
  } mac_ctrl_t;

endpackage

// File: hw/rtl/iir_df1_if.sv
// Valid/ready channel interfaces for the filter's sample input and result output.
// Depends on iir_df1_pkg for the payload types.
`timescale 1ns / 1ps

interface iir_df1_in_if import iir_df1_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  stamp_t  stamp_in;

  modport source (output valid, output sample_in, output stamp_in, input ready);
  modport sink   (input valid, input sample_in, input stamp_in, output ready);
endinterface

interface iir_df1_out_if import iir_df1_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered_out;
  stamp_t  stamp_out;

  modport source (output valid, output filtered_out, output stamp_out, input ready);
  modport sink   (input valid, input filtered_out, input stamp_out, output ready);
endinterface

// File: hw/rtl/iir_direct_form_one_filter.sv
// Third-order direct form I IIR filter with one shared multiply-accumulate unit.
// Each accepted input beat runs 7 MAC issues, one accumulate drain and one round/saturate
// step that registers the result, which waits while the previous result is not taken;
// a new beat is taken only once the filter is back in idle, as the multiplier is shared.
// Reset (rst_ni, async, active low) clears coefficients, delay lines and control.
// Depends on iir_df1_pkg, iir_df1_if, iir_df1_regs and iir_df1_mac.
`timescale 1ns / 1ps

module iir_direct_form_one_filter import iir_df1_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iir_df1_in_if.sink            in_i,
  iir_df1_out_if.source         out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_RESULT
  } state_e;

  state_e             state_q;
  logic [TAP_W-1:0]   tap_q;
  sample_t            x_q;
  stamp_t             stamp_q;
  sample_t            xd_q [ORDER];
  sample_t            yd_q [ORDER];
  logic               out_valid_q;
  sample_t            out_data_q;
  stamp_t             out_stamp_q;

  coef_bank_t         coef;
  mac_ctrl_t          mac_ctrl;
  coef_t              coef_sel;
  sample_t            samp_sel;
  logic               sub_sel;
  acc_t               acc;
  acc_t               acc_rnd;
  logic signed [SH_W-1:0] acc_sh;
  sample_t            y_sat;
  logic               accept;
  logic               load;

  iir_df1_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load       = (state_q == S_RESULT) && (!out_valid_q || out_o.ready);

  // Tap order: b0*x, then b1..bN on past inputs, then a1..aN on past outputs.
  always_comb begin
    coef_sel = coef[0];
    samp_sel = x_q;
    sub_sel  = 1'b0;
    for (int i = 0; i < ORDER; i++) begin
      if (tap_q == TAP_W'(i + 1)) begin
        coef_sel = coef[i + 1];
        samp_sel = xd_q[i];
      end
      if (tap_q == TAP_W'(ORDER + 1 + i)) begin
        coef_sel = coef[A1_REG_IDX + i];
        samp_sel = yd_q[i];
        sub_sel  = 1'b1;
      end
    end
  end

  assign mac_ctrl.clear = accept;
  assign mac_ctrl.issue = (state_q == S_MAC);
  assign mac_ctrl.sub   = sub_sel;

  iir_df1_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_sel),
    .sample_i (samp_sel),
    .acc_o    (acc)
  );

  // Round half up, drop the fraction, clamp to the sample range.
  always_comb begin
    acc_rnd = acc + ROUND_HALF;
    acc_sh  = acc_rnd[ACC_W-1:FRAC_BITS];
    if (acc_sh > SAT_MAX) begin
      y_sat = SAMPLE_W'(SAT_MAX);
    end else if (acc_sh < SAT_MIN) begin
      y_sat = SAMPLE_W'(SAT_MIN);
    end else begin
      y_sat = acc_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      x_q         <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_stamp_q <= '0;
      for (int i = 0; i < ORDER; i++) begin
        xd_q[i] <= '0;
        yd_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            x_q     <= in_i.sample_in;
            stamp_q <= in_i.stamp_in;
            tap_q   <= '0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (tap_q == LAST_TAP) begin
            state_q <= S_DRAIN;
          end else begin
            tap_q <= tap_q + TAP_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          // Wait here while the previous result has not been taken.
          if (load) begin
            out_valid_q <= 1'b1;
            out_data_q  <= y_sat;
            out_stamp_q <= stamp_q;
            for (int i = ORDER - 1; i > 0; i--) begin
              xd_q[i] <= xd_q[i - 1];
              yd_q[i] <= yd_q[i - 1];
            end
            xd_q[0] <= x_q;
            yd_q[0] <= y_sat;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.filtered_out = out_data_q;
  assign out_o.stamp_out    = out_stamp_q;

`ifndef ASSERT_OFF
  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MAC) && (tap_q == '0))
    else $error("accepted beat did not start the tap sequence at tap zero");

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (tap_q <= LAST_TAP))
    else $error("tap counter ran past the last tap");

  a_drain_after_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> ($past(state_q) == S_MAC) && ($past(tap_q) == LAST_TAP))
    else $error("drain entered before all taps were issued");

  a_load_sets_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && (state_q == S_IDLE) && (yd_q[0] == out_data_q))
    else $error("result load did not present the fed-back output");
`endif

endmodule

// File: hw/rtl/iir_df1_regs.sv
// APB coefficient register bank: b0..b3 and a1..a3, signed Q3.14.
// Depends on iir_df1_pkg.
`timescale 1ns / 1ps

module iir_df1_regs import iir_df1_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output coef_bank_t            coef_o
);

  coef_bank_t           coef_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign coef_o  = coef_q;

  // Addresses past the last register write nothing and read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (reg_idx == REG_IDX_W'(i)) begin
          coef_q[i] <= pwdata[COEF_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (reg_idx == REG_IDX_W'(i)) begin
        prdata = APB_DATA_W'(coef_q[i]);
      end
    end
  end

endmodule

// File: hw/rtl/iir_df1_mac.sv
// Shared multiply-accumulate unit: one registered 18x16 product per cycle,
// added to or subtracted from the accumulator in the following cycle. Depends on iir_df1_pkg.
`timescale 1ns / 1ps

module iir_df1_mac import iir_df1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  coef_t     coef_i,
  input  sample_t   sample_i,
  output acc_t      acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic                     prod_sub_q;
  acc_t                     acc_q;
  acc_t                     prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
      prod_sub_q <= ctrl_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * sample_i;
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= prod_sub_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule
